// ===== rtl/am_modulate_coherent_demod_boxcar_top_defines.svh =====
// Assertion macros for the AM modulator / coherent demodulator RTL.
// Expects signals named clk and arst_n in the scope of every use.
`ifndef AM_MODULATE_COHERENT_DEMOD_BOXCAR_TOP_DEFINES_SVH
`define AM_MODULATE_COHERENT_DEMOD_BOXCAR_TOP_DEFINES_SVH

// Clocked property check, switched off while reset is asserted
`define AMCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen at a clock edge
`define AMCD_NEVER(lbl, cond, msg) \
	`AMCD_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/amcd_pkg.sv =====
// Shared types, constants and the carrier table generator for the AM block.
// No dependencies.
`timescale 1ns / 1ps

package amcd_pkg;

	// Parameter defaults
	localparam int WINDOW_DEF         = 1000;
	localparam int COS_TABLE_BITS_DEF = 10;

	// Demodulated value width (Q2.15, signed)
	localparam int DEM_W = 17;

	// Configuration register map (word index) and reset value
	localparam logic REG_PHASE_STEP = 1'b0;
	localparam logic [31:0] PHASE_STEP_RST = 32'd1947830973;

	// Taylor series constants for the carrier table
	localparam int SERIES_TERMS = 12;
	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
	localparam longint unsigned ONE_Q30    = 64'd1073741824;

	// Controller to datapath commands, one per step
	typedef struct packed {
		logic load;
		logic tab;
		logic mul1;
		logic mul2;
		logic acc;
		logic div1;
		logic div2;
		logic div3;
		logic fin;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fill_done;
	} sts_t;

	// Q15 cosine (or sine) of a first-quadrant table point, evaluated at
	// elaboration. rem is the point within the quadrant, tb the table bits.
	function automatic logic [15:0] cos_quarter(input int unsigned rem, input int tb,
			input bit want_sin);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned ct;
		longint unsigned st;
		longint c;
		longint s;
		longint p;
		longint unsigned m;
		longint r;
		x  = (64'(rem) * TWO_PI_Q30) >> tb;
		x2 = (x * x) >> 30;
		ct = ONE_Q30;
		st = x;
		c  = longint'(ct);
		s  = longint'(st);
		for (int n = 1; n <= SERIES_TERMS; n++) begin
			ct = ((ct * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
			st = ((st * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if ((n % 2) == 1) begin
				c = c - longint'(ct);
				s = s - longint'(st);
			end else begin
				c = c + longint'(ct);
				s = s + longint'(st);
			end
		end
		p = (want_sin ? s : c) * 64'sd32767;
		m = (p < 0) ? longint'(-p) : longint'(p);
		r = longint'((m + 64'd536870912) >> 30);
		if (p < 0)
			r = -r;
		if (r > 32767)
			r = 32767;
		if (r < -32767)
			r = -32767;
		return 16'(r);
	endfunction

endpackage

// ===== rtl/amcd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module amcd_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/amcd_ctrl.sv =====
// Sequencer for the AM modulator / demodulator: handshakes and step commands.
// Depends on amcd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "am_modulate_coherent_demod_boxcar_top_defines.svh"

module amcd_ctrl
	import amcd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_TAB,
		S_MUL1,
		S_MUL2,
		S_ACC,
		S_DIV1,
		S_DIV2,
		S_DIV3,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// Output register may be loaded when empty or emptied this cycle
	assign out_free = !out_valid_q || !out_stall;

	// Step commands decoded from state
	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.tab  = (state_q == S_TAB);
		cmd.mul1 = (state_q == S_MUL1);
		cmd.mul2 = (state_q == S_MUL2);
		cmd.acc  = (state_q == S_ACC);
		cmd.div1 = (state_q == S_DIV1);
		cmd.div2 = (state_q == S_DIV2);
		cmd.div3 = (state_q == S_DIV3);
		cmd.fin  = (state_q == S_FIN) && out_free;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_TAB;
				end
				S_TAB:  state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_ACC;
				S_ACC: begin
					// average only needed once the window is full
					state_q <= sts.fill_done ? S_DIV1 : S_FIN;
				end
				S_DIV1: state_q <= S_DIV2;
				S_DIV2: state_q <= S_DIV3;
				S_DIV3: state_q <= S_FIN;
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Checks
	`AMCD_ASSERT(a_load_starts, cmd.load |=> (state_q == S_TAB), "accepted request did not start")
	`AMCD_ASSERT(a_fin_holds, (state_q == S_FIN && out_valid_q && out_stall) |=> (state_q == S_FIN), "result dropped under stall")
	`AMCD_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.tab, cmd.mul1, cmd.mul2, cmd.acc, cmd.div1, cmd.div2, cmd.div3, cmd.fin}), "overlapping step commands")
	`AMCD_ASSERT(a_valid_from_fin, $rose(out_valid_q) |-> ($past(state_q) == S_FIN), "result without finish step")
	`AMCD_ASSERT(a_skip_average, (cmd.acc && !sts.fill_done) |=> (state_q == S_FIN), "average computed on partial window")

endmodule

// ===== rtl/amcd_dp.sv =====
// Datapath: phase accumulator, carrier table, mixers, boxcar sum and average.
// Depends on amcd_pkg; history memory sits outside on the RAM ports.
`timescale 1ns / 1ps

module amcd_dp
	import amcd_pkg::*;
#(
	parameter int WINDOW         = WINDOW_DEF,
	parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic [31:0]               phase_step,
	input  logic                      start_of_signal,
	input  logic signed [15:0]        audio_sample,
	output logic signed [15:0]        modulated_sample,
	output logic signed [16:0]        filtered_sample,
	output logic                      filtered_valid,
	output logic                      ram_wr_en,
	output logic [$clog2(WINDOW)-1:0] ram_wr_addr,
	output logic [DEM_W-1:0]          ram_wr_data,
	output logic                      ram_rd_en,
	output logic [$clog2(WINDOW)-1:0] ram_rd_addr,
	input  logic [DEM_W-1:0]          ram_rd_data
);

	localparam int TB     = COS_TABLE_BITS;
	localparam int TQ     = 1 << (TB - 2);
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int SUM_W  = $clog2(WINDOW) + DEM_W;
	localparam int NW     = SUM_W;
	localparam int HALF_W = WINDOW / 2;
	localparam logic [NW-1:0] RECIP = NW'((64'd1 << NW) / WINDOW);

	// Quarter-wave carrier tables
	logic [15:0] cos_rom [TQ];
	logic [15:0] sin_rom [TQ];

	for (genvar gi = 0; gi < TQ; gi++) begin : g_rom
		assign cos_rom[gi] = cos_quarter(gi, TB, 1'b0);
		assign sin_rom[gi] = cos_quarter(gi, TB, 1'b1);
	end

	logic [31:0]              phase_q;
	logic [31:0]              phase_eff;
	logic [TB-1:0]            idx_q;
	logic signed [15:0]       sample_q;
	logic signed [15:0]       cos_q;
	logic signed [31:0]       prod1_q;
	logic signed [31:0]       prod2_q;
	logic signed [15:0]       mod_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [FILL_W-1:0]        fill_q;
	logic [SLOT_W-1:0]        slot_q;
	logic                     neg_q;
	logic [NW-1:0]            n_q;
	logic [2*NW-1:0]          prodr_q;
	logic [NW-1:0]            qe_q;
	logic [NW-1:0]            qw_q;
	logic signed [15:0]       mod_out_q;
	logic signed [16:0]       filt_q;
	logic                     fvalid_q;

	logic [1:0]               quad;
	logic [TB-3:0]            rem;
	logic [15:0]              cos_mag;
	logic                     cos_neg;
	logic signed [31:0]       mod_rnd;
	logic signed [15:0]       mod_sat;
	logic signed [31:0]       dem_rnd;
	logic signed [DEM_W-1:0]  dem_sat;
	logic signed [DEM_W-1:0]  old_dem;
	logic                     win_full;
	logic [SUM_W-1:0]         sum_mag;
	logic [NW-1:0]            rest;
	logic [NW-1:0]            quo;
	logic signed [16:0]       avg;

	// Phase used by this sample: a start flag restarts at zero
	assign phase_eff = start_of_signal ? 32'd0 : phase_q;

	// Quadrant fold of the table index
	assign quad    = idx_q[TB-1 -: 2];
	assign rem     = idx_q[TB-3:0];
	assign cos_mag = quad[0] ? sin_rom[rem] : cos_rom[rem];
	assign cos_neg = (quad == 2'd1) || (quad == 2'd2);

	// Modulated: round half away from zero at Q15, then saturate
	assign mod_rnd = (prod1_q + (prod1_q[31] ? 32'sd16383 : 32'sd16384)) >>> 15;
	always_comb begin
		if (mod_rnd > 32'sd32767)
			mod_sat = 16'sh7fff;
		else if (mod_rnd < -32'sd32768)
			mod_sat = -16'sh8000;
		else
			mod_sat = mod_rnd[15:0];
	end

	// Demodulated: product times two at Q15, i.e. shift by 14
	assign dem_rnd = (prod2_q + (prod2_q[31] ? 32'sd8191 : 32'sd8192)) >>> 14;
	always_comb begin
		if (dem_rnd > 32'sd65535)
			dem_sat = 17'sh0ffff;
		else if (dem_rnd < -32'sd65536)
			dem_sat = -17'sh10000;
		else
			dem_sat = dem_rnd[DEM_W-1:0];
	end

	assign old_dem  = $signed(ram_rd_data);
	assign win_full = (fill_q == FILL_W'(WINDOW));
	assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	// Window full once this accumulate has run
	assign sts.fill_done = (fill_q >= FILL_W'(WINDOW - 1));

	// History memory: read the outgoing slot, later overwrite it
	assign ram_rd_en   = cmd.tab;
	assign ram_rd_addr = slot_q;
	assign ram_wr_en   = cmd.acc;
	assign ram_wr_addr = slot_q;
	assign ram_wr_data = dem_sat;

	// Quotient correction: estimate is exact or one low
	assign rest = n_q - qw_q;
	assign quo  = (rest >= NW'(WINDOW)) ? qe_q + NW'(1) : qe_q;

	// Sign and saturate the average
	always_comb begin
		if (!neg_q) begin
			if (quo > NW'(65535))
				avg = 17'sh0ffff;
			else
				avg = quo[16:0];
		end else begin
			if (quo > NW'(65536))
				avg = -17'sh10000;
			else
				avg = -$signed(quo[16:0]);
		end
	end

	// Running state: phase, window sum, fill count, slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			sum_q   <= '0;
			fill_q  <= '0;
			slot_q  <= '0;
		end else begin
			if (cmd.load) begin
				phase_q <= phase_eff + phase_step;
				if (start_of_signal) begin
					sum_q  <= '0;
					fill_q <= '0;
					slot_q <= '0;
				end
			end
			if (cmd.acc) begin
				sum_q  <= sum_q - (win_full ? SUM_W'(old_dem) : '0) + SUM_W'(dem_sat);
				fill_q <= win_full ? fill_q : fill_q + FILL_W'(1);
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
			end
		end
	end

	// Per-sample working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q    <= phase_eff[31 -: TB];
			sample_q <= audio_sample;
		end
		if (cmd.tab)
			cos_q <= cos_neg ? -$signed(cos_mag) : $signed(cos_mag);
		if (cmd.mul1)
			prod1_q <= sample_q * cos_q;
		if (cmd.mul2) begin
			mod_q   <= mod_sat;
			prod2_q <= mod_sat * cos_q;
		end
		if (cmd.div1) begin
			neg_q <= sum_q[SUM_W-1];
			n_q   <= NW'(sum_mag) + NW'(HALF_W);
		end
		if (cmd.div2)
			prodr_q <= (2*NW)'(n_q) * (2*NW)'(RECIP);
		if (cmd.div3) begin
			qe_q <= prodr_q[2*NW-1 -: NW];
			qw_q <= prodr_q[2*NW-1 -: NW] * NW'(WINDOW);
		end
		if (cmd.fin) begin
			mod_out_q <= mod_q;
			filt_q    <= win_full ? avg : '0;
			fvalid_q  <= win_full;
		end
	end

	assign modulated_sample = mod_out_q;
	assign filtered_sample  = filt_q;
	assign filtered_valid   = fvalid_q;

endmodule

// ===== rtl/am_modulate_coherent_demod_boxcar_top.sv =====
// DSB-SC AM modulator, coherent demodulator and boxcar average, one sample a request.
// One request at a time: a new sample is accepted only after the last has left the
// finish step, which holds under output stall; the divide is skipped while filling.
// Reset (arst_n low): phase, window sum, fill count, slot and phase_step restored;
// the history memory is not cleared, the fill count keeps unwritten slots unread.
`timescale 1ns / 1ps

module am_modulate_coherent_demod_boxcar_top
	import amcd_pkg::*;
#(
	parameter int WINDOW         = WINDOW_DEF,
	parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               start_of_signal,
	input  logic signed [15:0] audio_sample,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] modulated_sample,
	output logic signed [16:0] filtered_sample,
	output logic               filtered_valid,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int SLOT_W = $clog2(WINDOW);

	logic [31:0]       phase_step_q;
	cmd_t              cmd;
	sts_t              sts;
	logic              ram_wr_en;
	logic [SLOT_W-1:0] ram_wr_addr;
	logic [DEM_W-1:0]  ram_wr_data;
	logic              ram_rd_en;
	logic [SLOT_W-1:0] ram_rd_addr;
	logic [DEM_W-1:0]  ram_rd_data;

	// Register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PHASE_STEP) ? phase_step_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_PHASE_STEP)) begin
			phase_step_q <= pwdata;
		end
	end

	// Sequencer
	amcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Arithmetic
	amcd_dp #(
		.WINDOW         (WINDOW),
		.COS_TABLE_BITS (COS_TABLE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.phase_step       (phase_step_q),
		.start_of_signal  (start_of_signal),
		.audio_sample     (audio_sample),
		.modulated_sample (modulated_sample),
		.filtered_sample  (filtered_sample),
		.filtered_valid   (filtered_valid),
		.ram_wr_en        (ram_wr_en),
		.ram_wr_addr      (ram_wr_addr),
		.ram_wr_data      (ram_wr_data),
		.ram_rd_en        (ram_rd_en),
		.ram_rd_addr      (ram_rd_addr),
		.ram_rd_data      (ram_rd_data)
	);

	// Demodulated history
	amcd_ram #(
		.WIDTH (DEM_W),
		.DEPTH (WINDOW)
	) u_hist (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule
